@@ design/hes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hes_pkg: shared types and tables for the html escape stream
// Character classes, entity spellings and configuration register codes.
// ----------------------------------------------------------------------------
package hes_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register index taken from paddr bit 2
	localparam logic REG_OUT_CAPACITY = 1'b0;

	localparam logic [15:0] CAP_RESET = 16'd128;

	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_SUBST = 8'h3F;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;

	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_AMP,
		KIND_LT,
		KIND_GT,
		KIND_QUOT,
		KIND_APOS
	} kind_t;

	// classify a source byte
	function automatic kind_t char_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_AMP:  k = KIND_AMP;
			CH_LT:   k = KIND_LT;
			CH_GT:   k = KIND_GT;
			CH_QUOT: k = KIND_QUOT;
			CH_APOS: k = KIND_APOS;
			default: k = KIND_PLAIN;
		endcase
		return k;
	endfunction

	// number of bytes in the entity for a class
	function automatic logic [2:0] ent_len(input kind_t k);
		logic [2:0] n;
		case (k)
			KIND_AMP:  n = 3'd5;
			KIND_LT:   n = 3'd4;
			KIND_GT:   n = 3'd4;
			KIND_QUOT: n = 3'd6;
			KIND_APOS: n = 3'd5;
			default:   n = 3'd1;
		endcase
		return n;
	endfunction

	// byte idx of the entity for a class
	function automatic logic [7:0] ent_byte(input kind_t k, input logic [2:0] idx);
		logic [7:0] b;
		b = 8'h3B; // ';' closes every entity
		if (idx == 3'd0) begin
			b = CH_AMP;
		end else begin
			case (k)
				KIND_AMP: begin
					case (idx)
						3'd1:    b = 8'h61; // a
						3'd2:    b = 8'h6D; // m
						3'd3:    b = 8'h70; // p
						default: b = 8'h3B;
					endcase
				end
				KIND_LT: begin
					case (idx)
						3'd1:    b = 8'h6C; // l
						3'd2:    b = 8'h74; // t
						default: b = 8'h3B;
					endcase
				end
				KIND_GT: begin
					case (idx)
						3'd1:    b = 8'h67; // g
						3'd2:    b = 8'h74; // t
						default: b = 8'h3B;
					endcase
				end
				KIND_QUOT: begin
					case (idx)
						3'd1:    b = 8'h71; // q
						3'd2:    b = 8'h75; // u
						3'd3:    b = 8'h6F; // o
						3'd4:    b = 8'h74; // t
						default: b = 8'h3B;
					endcase
				end
				KIND_APOS: begin
					case (idx)
						3'd1:    b = 8'h23; // #
						3'd2:    b = 8'h33; // 3
						3'd3:    b = 8'h39; // 9
						default: b = 8'h3B;
					endcase
				end
				default: b = 8'h3B;
			endcase
		end
		return b;
	endfunction

endpackage

@@ design/hes_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hes_if: stream channels of the html escape stream
// Source character channel and escaped byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hes_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

interface hes_dst_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [15:0] out_pos;
	logic        is_terminator;
	logic        truncated;
	logic        run_last;

	modport source (output valid, output out_byte, output out_pos, output is_terminator,
		output truncated, output run_last, input ready);
	modport sink (input valid, input out_byte, input out_pos, input is_terminator,
		input truncated, input run_last, output ready);
endinterface

@@ design/html_escape_stream_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_escape_stream_top: streaming html escaper into a bounded buffer
// A source item passes through the input register and then the result register.
// Throughput: one item per cycle for single-byte results while the output is ready; an
// entity item is held while the single result register emits its four to six bytes in turn.
// Reset: write position 0, string open, out_capacity 128, channels empty.
// ----------------------------------------------------------------------------
module html_escape_stream_top
	import hes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	hes_src_if.sink           src,
	hes_dst_if.source         dst
);

	logic [15:0] cap_q;
	logic        reg_sel;

	// configuration register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_OUT_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[15:0];
		end
	end

	assign prdata = reg_sel ? {16'd0, cap_q} : '0;

	// escape datapath
	hes_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.out_capacity (cap_q),
		.src          (src),
		.dst          (dst)
	);

	// a truncation flag only rides on the closing terminator
	assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid && dst.truncated |-> dst.is_terminator && dst.run_last)
		else $error("truncated set on a non-terminator result");

	// terminators carry a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid && dst.is_terminator |-> dst.out_byte == 8'h00 && dst.run_last)
		else $error("terminator with non-zero byte");

	// entity bytes follow each other at consecutive positions
	assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid && dst.ready && !dst.run_last |=>
			dst.valid && dst.out_pos == $past(dst.out_pos) + 16'd1)
		else $error("entity byte missing or out of place");

endmodule

@@ design/hes_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hes_core: escape datapath
// Input register, escape decision and a result register that emits one byte per cycle while the output is ready.
// ----------------------------------------------------------------------------
module hes_core
	import hes_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   out_capacity,
	hes_src_if.sink       src,
	hes_dst_if.source     dst
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic [15:0] wpos_q;
	logic        closed_q;
	logic [2:0]  idx_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [15:0] out_pos_q;
	logic        out_term_q;
	logic        out_trunc_q;
	logic        out_last_q;

	kind_t       kind;
	logic [2:0]  rep_len;
	logic [15:0] cap_eff;
	logic        full_one;
	logic        full_rep;
	logic        is_end;
	logic        is_trunc;
	logic        has_res;
	logic [7:0]  res_byte;
	logic [15:0] res_pos;
	logic        res_term;
	logic        res_trunc;
	logic        res_last;
	logic        out_load;
	logic        consume;
	logic [15:0] wpos_next;

	// escape decision for the held item
	always_comb begin
		kind      = char_kind(char_s1);
		rep_len   = ent_len(kind);
		cap_eff   = (out_capacity == 16'd0) ? 16'd1 : out_capacity;
		full_one  = ({1'b0, wpos_q} + 17'd1) >= {1'b0, cap_eff};
		full_rep  = (kind != KIND_PLAIN) &&
			(({1'b0, wpos_q} + {14'd0, rep_len}) >= {1'b0, cap_eff});
		is_end    = (char_s1 == CH_END);
		is_trunc  = !is_end && !closed_q && (full_one || full_rep);
		has_res   = is_end ? !closed_q : !closed_q;
		res_byte  = 8'h00;
		res_pos   = wpos_q;
		res_term  = 1'b0;
		res_trunc = 1'b0;
		res_last  = 1'b1;
		wpos_next = wpos_q + 16'd1;
		if (is_end) begin
			res_term = 1'b1;
		end else if (is_trunc) begin
			res_term  = 1'b1;
			res_trunc = 1'b1;
		end else if (kind != KIND_PLAIN) begin
			res_byte  = ent_byte(kind, idx_q);
			res_pos   = wpos_q + {13'd0, idx_q};
			res_last  = (idx_q == rep_len - 3'd1);
			wpos_next = wpos_q + {13'd0, rep_len};
		end else if (char_s1 >= CH_SPACE && char_s1 != CH_DEL) begin
			res_byte = char_s1;
		end else begin
			res_byte = CH_SUBST;
		end
	end

	// handshake between the input register and the result register
	assign out_load  = valid_s1 && has_res && (!out_valid_q || dst.ready);
	assign consume   = valid_s1 && (!has_res || (out_load && res_last));
	assign src.ready = !valid_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) begin
			char_s1 <= src.char_byte;
		end
	end

	// position, closed flag and entity byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q   <= 16'd0;
			closed_q <= 1'b0;
			idx_q    <= 3'd0;
		end else if (consume) begin
			idx_q <= 3'd0;
			if (is_end) begin
				wpos_q   <= 16'd0;
				closed_q <= 1'b0;
			end else if (is_trunc) begin
				closed_q <= 1'b1;
			end else if (!closed_q) begin
				wpos_q <= wpos_next;
			end
		end else if (out_load) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q  <= res_byte;
			out_pos_q   <= res_pos;
			out_term_q  <= res_term;
			out_trunc_q <= res_trunc;
			out_last_q  <= res_last;
		end
	end

	assign dst.valid         = out_valid_q;
	assign dst.out_byte      = out_byte_q;
	assign dst.out_pos       = out_pos_q;
	assign dst.is_terminator = out_term_q;
	assign dst.truncated     = out_trunc_q;
	assign dst.run_last      = out_last_q;

endmodule

@@ tb/hes_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hes_checker: escaped byte predictor and scoreboard
// Watches the register port and both channels, works out the escaped bytes
// for every accepted source item and compares each output item in order.
// ----------------------------------------------------------------------------
module hes_checker
	import hes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	hes_src_if                src,
	hes_dst_if                dst,
	output int                err_count,
	output int                pending
);

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] out_pos;
		logic        is_terminator;
		logic        truncated;
		logic        run_last;
	} esc_byte_t;

	esc_byte_t   expected_bytes[$];
	logic [15:0] capacity = CAP_RESET;
	int          write_pos = 0;
	logic        closed = 1'b0;

	// entity spelling for the five special characters, empty for plain bytes
	function automatic string entity_of(input logic [7:0] c);
		case (c)
			CH_AMP:  return "&amp;";
			CH_LT:   return "&lt;";
			CH_GT:   return "&gt;";
			CH_QUOT: return "&quot;";
			CH_APOS: return "&#39;";
			default: return "";
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b, input int pos, input logic term,
		input logic trunc, input logic last);
		esc_byte_t e;
		e.out_byte      = b;
		e.out_pos       = pos[15:0];
		e.is_terminator = term;
		e.truncated     = trunc;
		e.run_last      = last;
		expected_bytes.push_back(e);
	endtask

	// escape one source character against the current buffer state
	task automatic escape_char(input logic [7:0] c);
		string      ent;
		int         cap;
		int         n;
		logic [7:0] b;
		cap = (capacity == 16'd0) ? 1 : int'(capacity);
		ent = entity_of(c);
		n = (ent.len() == 0) ? 1 : ent.len();
		if (c == CH_END) begin
			if (!closed) begin
				push_byte(CH_END, write_pos, 1'b1, 1'b0, 1'b1);
			end
			write_pos = 0;
			closed = 1'b0;
		end else if (!closed) begin
			// no room for the byte or the whole entity: close with a terminator
			if (write_pos + n >= cap) begin
				push_byte(CH_END, write_pos, 1'b1, 1'b1, 1'b1);
				closed = 1'b1;
			end else if (ent.len() == 0) begin
				b = (c < CH_SPACE || c == CH_DEL) ? CH_SUBST : c;
				push_byte(b, write_pos, 1'b0, 1'b0, 1'b1);
				write_pos = write_pos + 1;
			end else begin
				for (int i = 0; i < n; i++) begin
					push_byte(ent[i], write_pos + i, 1'b0, 1'b0, i == n - 1);
				end
				write_pos = write_pos + n;
			end
		end
	endtask

	function automatic int compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// compare one output item with the oldest expected byte
	task automatic check_byte();
		esc_byte_t want;
		if (expected_bytes.size() == 0) begin
			$error("unexpected item: out_byte %0h at out_pos %0d", dst.out_byte, dst.out_pos);
			err_count++;
		end else begin
			want = expected_bytes.pop_front();
			err_count += compare_field("out_byte", 16'(want.out_byte), 16'(dst.out_byte));
			err_count += compare_field("out_pos", want.out_pos, dst.out_pos);
			err_count += compare_field("is_terminator", 16'(want.is_terminator),
				16'(dst.is_terminator));
			err_count += compare_field("truncated", 16'(want.truncated), 16'(dst.truncated));
			err_count += compare_field("run_last", 16'(want.run_last), 16'(dst.run_last));
		end
	endtask

	// track register writes, predict on source items, check on output items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity = CAP_RESET;
			write_pos = 0;
			closed = 1'b0;
			expected_bytes.delete();
			err_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_CAPACITY) begin
				capacity = pwdata[15:0];
			end
			if (src.valid && src.ready) begin
				escape_char(src.char_byte);
			end
			if (dst.valid && dst.ready) begin
				check_byte();
			end
		end
		pending = expected_bytes.size();
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the html escape stream
// Drives strings through the source channel and capacity writes through the
// register port, with random idling on both channels and one long output
// hold-off; the checker predicts every escaped byte and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
	import hes_pkg::*;

	localparam int LIMIT       = 300000;
	localparam int CFG_GAP     = 8;
	localparam int DRAIN       = 10;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 81;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int err_count;
	int pending;
	int src_idle_pct = 18;
	int dst_idle_pct = 45;
	int stall_req = 0;
	int stall_done = 0;
	int stall_left = 0;
	int sent = 0;

	hes_src_if src();
	hes_dst_if dst();

	html_escape_stream_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.src     (src),
		.dst     (dst)
	);

	hes_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.src       (src),
		.dst       (dst),
		.err_count (err_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// output side: random idling, or a long hold-off when one is requested
	initial begin
		dst.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				dst.ready <= 1'b0;
				stall_left--;
			end else if (stall_done != stall_req) begin
				stall_done++;
				stall_left = HOLD_CYCLES;
				dst.ready <= 1'b0;
			end else begin
				dst.ready <= ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	// offer one character and hold it until accepted
	task automatic send_char(input logic [7:0] c);
		logic done;
		while ($urandom_range(99) < src_idle_pct) begin
			src.valid <= 1'b0;
			@(negedge clk);
		end
		src.valid <= 1'b1;
		src.char_byte <= c;
		do begin
			@(posedge clk);
			done = src.ready;
			@(negedge clk);
		end while (!done);
		sent++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
	endtask

	// stop offering, wait for every expected byte, then let dropped items drain
	task automatic go_idle();
		src.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (CFG_GAP) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] cap);
		go_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_OUT_CAPACITY, 2'b00};
		pwdata  <= {16'($urandom), cap};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// weighted toward special characters and control bytes
	function automatic logic [7:0] random_char();
		int r;
		r = $urandom_range(99);
		if (r < 30) begin
			case ($urandom_range(4))
				0: return CH_AMP;
				1: return CH_LT;
				2: return CH_GT;
				3: return CH_QUOT;
				default: return CH_APOS;
			endcase
		end else if (r < 40) begin
			return ($urandom_range(4) == 0) ? CH_DEL : 8'($urandom_range(1, 31));
		end
		return 8'($urandom_range(1, 255));
	endfunction

	// mostly small buffers so truncation comes often
	function automatic logic [15:0] pick_capacity();
		case ($urandom_range(7))
			0: return 16'd1;
			1: return 16'd2;
			2, 3: return 16'($urandom_range(3, 12));
			4, 5: return 16'($urandom_range(13, 40));
			6: return CAP_RESET;
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic send_random_string();
		int len;
		len = $urandom_range(1, 20);
		if ($urandom_range(9) == 0) begin
			send_char(CH_END);
		end else begin
			repeat (len) send_char(random_char());
			send_char(CH_END);
		end
	endtask

	initial begin
		int goal;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src.valid = 1'b0;
		src.char_byte = 8'h00;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every character class at the reset capacity, then an empty string
		send_char(8'h01);
		send_char(8'h1F);
		send_char(CH_SPACE);
		send_char(8'h7E);
		send_char(CH_DEL);
		send_char(8'h80);
		send_char(8'hFF);
		send_char(CH_AMP);
		send_char(CH_LT);
		send_char(CH_GT);
		send_char(CH_QUOT);
		send_char(CH_APOS);
		send_char(CH_END);
		send_char(CH_END);

		// only the terminator slot, and capacity zero behaving as one
		write_capacity(16'd1);
		send_str("x");
		send_char(CH_END);
		write_capacity(16'd0);
		send_str("y");
		send_char(CH_END);

		// entity that exactly fits, then one that does not, then dropped bytes
		write_capacity(16'd6);
		send_char(CH_AMP);
		send_char(CH_END);
		send_char(CH_QUOT);
		send_str("q");
		send_char(CH_END);

		// capacity lowered below the current position mid-string
		write_capacity(16'd16);
		send_str("ab");
		write_capacity(16'd2);
		send_str("c");
		send_char(CH_END);

		// random strings in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				src_idle_pct = 45;
				dst_idle_pct = 18;
			end else if (phase == 2) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
				// long output hold-off while a fresh string keeps coming
				write_capacity(CAP_RESET);
				send_char(CH_END);
				stall_req++;
				send_str("a<b&c>d");
			end
			goal = sent + PHASE_ITEMS;
			while (sent < goal) begin
				if ($urandom_range(3) == 0) begin
					write_capacity(pick_capacity());
				end
				send_random_string();
			end
		end

		go_idle();
		repeat (DRAIN) @(negedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/hes_pkg.sv
design/hes_if.sv
design/hes_core.sv
design/html_escape_stream_top.sv
tb/hes_checker.sv
tb/tb_top.sv
